// ===== hw/rtl/chsq_pkg.sv =====
// Shared widths, state encoding and controller/datapath command types
// for the chi-squared histogram distance core. No dependencies.
`default_nettype none

package chsq_pkg;

   localparam int BIN_W  = 17;
   localparam int EPS_W  = 16;
   localparam int DIST_W = 27;
   localparam int SUM_W  = 29;
   localparam int DIFF_W = BIN_W;
   localparam int NUM_W  = 2 * DIFF_W;
   localparam int DEN_W  = BIN_W + 2;
   localparam int QUO_W  = BIN_W;
   localparam int STEP_W = $clog2(QUO_W);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_ACCUM
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic div_init;
      logic div_step;
      logic accum;
   } dp_cmd_type;

   typedef struct packed {
      logic last_bin;
      logic out_blocked;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/chsq_if.sv =====
// Valid/ready channel interfaces for requests, responses and the epsilon
// register write. Depends on chsq_pkg.
`default_nettype none

interface chsq_req_if;
   import chsq_pkg::*;
   logic             valid;
   logic             ready;
   logic [BIN_W-1:0] bin_a;
   logic [BIN_W-1:0] bin_b;
   logic             last_bin;
   modport source (output valid, bin_a, bin_b, last_bin, input ready);
   modport sink (input valid, bin_a, bin_b, last_bin, output ready);
endinterface

interface chsq_rsp_if;
   import chsq_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              saturated;
   modport source (output valid, distance, saturated, input ready);
   modport sink (input valid, distance, saturated, output ready);
endinterface

interface chsq_csr_if;
   import chsq_pkg::*;
   logic             valid;
   logic             ready;
   logic [EPS_W-1:0] epsilon;
   modport source (output valid, epsilon, input ready);
   modport sink (input valid, epsilon, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chsq_ctrl.sv =====
// Controller state machine: sequences square, divide and accumulate
// steps for one bin pair. Depends on chsq_pkg.
`default_nettype none

module chsq_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  chsq_pkg::dp_status_type status,
   output chsq_pkg::dp_cmd_type    cmd
);
   import chsq_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIVIDE;
            step_in  = '0;
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_ACCUM;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_ACCUM: begin
            if (!(status.last_bin && status.out_blocked)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_ACCUM: begin
            cmd.accum = !(status.last_bin && status.out_blocked);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/chsq_dpath.sv =====
// Datapath: operand registers, 17x17 squarer, restoring divider, saturating
// accumulator, epsilon register and response register. Depends on chsq_pkg.
`default_nettype none

module chsq_dpath (
   input  wire                       clock,
   input  wire                       reset,
   input  chsq_pkg::dp_cmd_type      cmd,
   output chsq_pkg::dp_status_type   status,
   input  wire [chsq_pkg::BIN_W-1:0] req_bin_a,
   input  wire [chsq_pkg::BIN_W-1:0] req_bin_b,
   input  wire                       req_last_bin,
   input  wire                       csr_write,
   input  wire [chsq_pkg::EPS_W-1:0] csr_epsilon,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [chsq_pkg::DIST_W-1:0] rsp_distance,
   output logic                      rsp_saturated
);
   import chsq_pkg::*;

   localparam logic [SUM_W:0]    SUM_MAX  = {1'b0, {SUM_W{1'b1}}};
   localparam logic [SUM_W-2:0]  DIST_MAX = {1'b0, {DIST_W{1'b1}}};

   logic [EPS_W-1:0]  eps_ff, eps_in;
   logic [BIN_W-1:0]  a_ff, b_ff;
   logic              last_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic              den_zero_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic              out_valid_ff, out_valid_in;
   logic [DIST_W-1:0] dist_ff;
   logic              sat_ff;

   logic [DIFF_W-1:0] diff;
   logic [DEN_W-1:0]  den;
   logic [DEN_W:0]    rem_shift;
   logic [DEN_W+1:0]  trial;
   logic              borrow;
   logic [QUO_W-1:0]  term;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_clamp;
   logic              ovf_next;
   logic [SUM_W-2:0]  half;
   logic              half_over;

   assign diff = (a_ff >= b_ff) ? (a_ff - b_ff) : (b_ff - a_ff);
   assign den  = DEN_W'(a_ff) + DEN_W'(b_ff) + DEN_W'(eps_ff);

   assign rem_shift = {rem_ff, quo_ff[QUO_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, den_ff};
   assign borrow    = trial[DEN_W+1];

   assign term      = den_zero_ff ? '0 : quo_ff;
   assign sum_wide  = {1'b0, sum_ff} + (SUM_W + 1)'(term);
   assign ovf_next  = ovf_ff || (sum_wide > SUM_MAX);
   assign sum_clamp = (sum_wide > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_wide[SUM_W-1:0];
   assign half      = sum_clamp[SUM_W-1:1];
   assign half_over = half > DIST_MAX;

   always_comb begin
      eps_in       = csr_write ? csr_epsilon : eps_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.accum) begin
         if (last_ff) begin
            sum_in       = '0;
            ovf_in       = 1'b0;
            out_valid_in = 1'b1;
         end else begin
            sum_in = sum_clamp;
            ovf_in = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         eps_ff       <= eps_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= req_bin_a;
         b_ff    <= req_bin_b;
         last_ff <= req_last_bin;
      end
      if (cmd.square) begin
         num_ff      <= NUM_W'(diff) * NUM_W'(diff);
         den_ff      <= den;
         den_zero_ff <= (den == '0);
      end
      if (cmd.div_init) begin
         rem_ff <= DEN_W'(num_ff[NUM_W-1:QUO_W]);
         quo_ff <= num_ff[QUO_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= borrow ? rem_shift[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], !borrow};
      end
      if (cmd.accum && last_ff) begin
         dist_ff <= half_over ? DIST_MAX[DIST_W-1:0] : half[DIST_W-1:0];
         sat_ff  <= ovf_next || half_over;
      end
   end

   assign status.last_bin    = last_ff;
   assign status.out_blocked = out_valid_ff && !rsp_ready;
   assign rsp_valid          = out_valid_ff;
   assign rsp_distance       = dist_ff;
   assign rsp_saturated      = sat_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/chi_squared_hist_distance_core.sv =====
// Chi-squared histogram distance core: top level joining controller and
// datapath to the channel interfaces. Depends on chsq_pkg, chsq_if.
//
// Usage:
//   req: one transaction per bin pair (bin_a, bin_b, last_bin), unsigned
//        fixed point with 16 fraction bits. last_bin closes a histogram.
//   rsp: one transaction per histogram: distance = half the summed
//        (a-b)^2/(a+b+epsilon) terms, saturated to 27 bits, with saturated
//        flagging overflow of the sum or of the result.
//   csr: writes epsilon; always ready. Write only while the core is idle.
// Sequence: one bin pair at a time (accept, square, divider load,
//   17 restoring divide steps, accumulate); the radix-2 divider produces
//   one quotient bit per cycle, and the next pair is taken after accumulate.
// Response: registered in the accumulate step of the last_bin pair.
// Stall: the response is held in an output register; the core accepts and
//   processes further bin pairs meanwhile, and waits in the accumulate step
//   only if a second last_bin result is ready while the first is not taken.
// Reset: clears the sum, the overflow flag, epsilon and the response valid.
`default_nettype none

module chi_squared_hist_distance_core (
   input  wire        clock,
   input  wire        reset,
   chsq_req_if.sink   req_chan,
   chsq_rsp_if.source rsp_chan,
   chsq_csr_if.sink   csr_chan
);
   import chsq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   chsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   chsq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_bin_a     (req_chan.bin_a),
      .req_bin_b     (req_chan.bin_b),
      .req_last_bin  (req_chan.last_bin),
      .csr_write     (csr_chan.valid),
      .csr_epsilon   (csr_chan.epsilon),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_distance  (rsp_chan.distance),
      .rsp_saturated (rsp_chan.saturated)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/chsq_checker.sv =====
// Port-level checker for the chi-squared distance core, bound to the top
// level. Depends on chsq_pkg and chi_squared_hist_distance_core.
`default_nettype none

module chsq_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire [chsq_pkg::DIST_W-1:0] rsp_distance,
   input wire                       rsp_saturated
);
   import chsq_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
         && $stable(rsp_saturated))
      else $error("stalled response changed");

   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_distance == {DIST_W{1'b1}}))
      else $error("saturated response below full scale");

endmodule

bind chi_squared_hist_distance_core chsq_checker u_chsq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_distance  (rsp_chan.distance),
   .rsp_saturated (rsp_chan.saturated)
);

`default_nettype wire

// ===== tb/chi_squared_hist_distance_core_test.sv =====
// Testbench for chi_squared_hist_distance_core: directed and random histogram pairs, checked
// against a fixed-point chi-squared predictor held in a small scoreboard class.
// Depends on chsq_pkg, chsq_if and the core RTL.
`timescale 1ns / 1ps

module chi_squared_hist_distance_core_test;
   import chsq_pkg::*;

   localparam int          SUM_EXT_W     = SUM_W + 1;
   localparam int unsigned SETTLE_CYCLES = 30;
   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam int unsigned RANDOM_ITEMS  = 135;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              saturated;
   } distance_result_type;

   class distance_scoreboard_type;
      bit [EPS_W-1:0]      epsilon;
      bit [SUM_W-1:0]      term_sum;
      bit                  overflow_seen;
      distance_result_type pending_distances[$];
      int unsigned         errors;
      int unsigned         bins_seen;
      int unsigned         distances_checked;

      function void add_bin_pair(bit [BIN_W-1:0] a, bit [BIN_W-1:0] b, bit last_bin);
         bit [DIFF_W-1:0]     diff;
         bit [NUM_W-1:0]      num;
         bit [DEN_W-1:0]      den;
         bit [QUO_W-1:0]      quo;
         bit [SUM_EXT_W-1:0]  sum;
         bit [SUM_W-2:0]      half;
         distance_result_type res;
         diff = (a >= b) ? a - b : b - a;
         num  = NUM_W'(diff) * NUM_W'(diff);
         den  = DEN_W'(a) + DEN_W'(b) + DEN_W'(epsilon);
         quo  = (den == '0) ? '0 : QUO_W'(num / NUM_W'(den));
         sum  = SUM_EXT_W'(term_sum) + SUM_EXT_W'(quo);
         bins_seen++;
         if (sum > SUM_EXT_W'({SUM_W{1'b1}})) begin
            sum = SUM_EXT_W'({SUM_W{1'b1}});
            overflow_seen = 1'b1;
         end
         term_sum = SUM_W'(sum);
         if (last_bin) begin
            half = term_sum[SUM_W-1:1];
            res.saturated = overflow_seen;
            if (half > (SUM_W-1)'({DIST_W{1'b1}})) begin
               half = (SUM_W-1)'({DIST_W{1'b1}});
               res.saturated = 1'b1;
            end
            res.distance = DIST_W'(half);
            pending_distances = {pending_distances, res};
            term_sum = '0;
            overflow_seen = 1'b0;
         end
      endfunction

      function void check_distance(logic [DIST_W-1:0] distance, logic saturated);
         distance_result_type exp_res;
         if (pending_distances.size() == 0) begin
            $error("unexpected result transaction: distance %0d saturated %0d",
                   distance, saturated);
            errors++;
            return;
         end
         exp_res = pending_distances.pop_front();
         distances_checked++;
         if (distance !== exp_res.distance) begin
            $error("distance mismatch: expected %0d, actual %0d", exp_res.distance, distance);
            errors++;
         end
         if (saturated !== exp_res.saturated) begin
            $error("saturated mismatch: expected %0d, actual %0d",
                   exp_res.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   chsq_req_if req_chan ();
   chsq_rsp_if rsp_chan ();
   chsq_csr_if csr_chan ();

   chi_squared_hist_distance_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   distance_scoreboard_type board = new();

   int unsigned cycle_count     = 0;
   int unsigned rsp_stall_left  = 0;
   bit          rsp_stalls_on   = 1'b0;
   bit          steady_mode     = 1'b0;
   int unsigned epsilon_writes  = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("chi_squared_hist_distance_core_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!rsp_stalls_on || $urandom_range(0, 2) != 0) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_distance(rsp_chan.distance, rsp_chan.saturated);
      end
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (steady_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic bit [BIN_W-1:0] random_bin();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return BIN_W'(65536);
         2: return '1;
         3: return BIN_W'($urandom_range(0, 15));
         4: return BIN_W'($urandom_range(65537, 131071));
         5: return BIN_W'($urandom);
         default: return BIN_W'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic send_bin_pair(input bit [BIN_W-1:0] a, input bit [BIN_W-1:0] b,
                                input bit last_bin);
      int unsigned gap;
      req_chan.valid    <= 1'b1;
      req_chan.bin_a    <= a;
      req_chan.bin_b    <= b;
      req_chan.last_bin <= last_bin;
      do @(posedge clock); while (!req_chan.ready);
      board.add_bin_pair(a, b, last_bin);
      gap = idle_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (board.pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_epsilon(input bit [EPS_W-1:0] value);
      wait_idle();
      csr_chan.valid   <= 1'b1;
      csr_chan.epsilon <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      board.epsilon = value;
      epsilon_writes++;
   endtask

   task automatic run_random_histograms(input int unsigned item_goal);
      int unsigned        sent;
      int unsigned        len;
      int unsigned        r;
      bit [BIN_W-1:0]     a;
      bit [BIN_W-1:0]     b;
      sent = 0;
      while (sent < item_goal) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            len = $urandom_range(1, 6);
         end else if (r < 9) begin
            len = $urandom_range(7, 24);
         end else begin
            len = $urandom_range(25, 80);
         end
         for (int unsigned i = 0; i < len; i++) begin
            a = random_bin();
            case ($urandom_range(0, 7))
               0: b = a;
               1: b = a ^ BIN_W'($urandom_range(1, 3));
               default: b = random_bin();
            endcase
            send_bin_pair(a, b, i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      bit [EPS_W-1:0] eps_plan[6];
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.bin_a    <= '0;
      req_chan.bin_b    <= '0;
      req_chan.last_bin <= 1'b0;
      csr_chan.valid    <= 1'b0;
      csr_chan.epsilon  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // epsilon still at its reset value: zero denominator and full-scale bins
      rsp_stalls_on = 1'b1;
      send_bin_pair('0, '0, 1'b1);
      send_bin_pair(BIN_W'(65536), '0, 1'b1);
      send_bin_pair('1, '1, 1'b1);
      send_bin_pair('1, '0, 1'b0);
      send_bin_pair('0, '1, 1'b1);

      write_epsilon('1);
      send_bin_pair('0, '0, 1'b1);
      send_bin_pair(BIN_W'(65536), BIN_W'(65536), 1'b1);
      send_bin_pair(BIN_W'(1), '0, 1'b1);
      send_bin_pair(BIN_W'(65536), '0, 1'b0);
      send_bin_pair('0, BIN_W'(65536), 1'b0);
      send_bin_pair(BIN_W'(12345), BIN_W'(54321), 1'b1);
      send_bin_pair('1, BIN_W'(1), 1'b1);
      send_bin_pair(BIN_W'('h15555), BIN_W'('h0aaaa), 1'b1);

      write_epsilon(EPS_W'(1));
      send_bin_pair('0, '0, 1'b1);
      send_bin_pair(BIN_W'('h0aaaa), BIN_W'('h15555), 1'b1);

      eps_plan[0] = '0;
      eps_plan[1] = '1;
      eps_plan[2] = EPS_W'($urandom_range(1, 16));
      eps_plan[3] = EPS_W'(32768);
      eps_plan[4] = EPS_W'($urandom_range(0, 65535));
      eps_plan[5] = EPS_W'($urandom_range(0, 65535));
      for (int p = 0; p < 6; p++) begin
         write_epsilon(eps_plan[p]);
         rsp_stalls_on = (p % 2 == 0);
         steady_mode   = (p == 3);
         run_random_histograms(RANDOM_ITEMS);
      end
      steady_mode = 1'b0;

      wait_idle();
      $display("Ran %0d bin pairs and checked %0d distances over %0d epsilon writes,",
               board.bins_seen, board.distances_checked, epsilon_writes);
      $display("including zero denominators, bins above 1.0 and stalled responses.");
      if (board.errors == 0) begin
         $display("chi_squared_hist_distance_core_test: PASS");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("chi_squared_hist_distance_core_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== chi_squared_hist_distance_core.f =====
hw/rtl/chsq_pkg.sv
hw/rtl/chsq_if.sv
hw/rtl/chsq_ctrl.sv
hw/rtl/chsq_dpath.sv
hw/rtl/chi_squared_hist_distance_core.sv
hw/rtl/chsq_checker.sv
tb/chi_squared_hist_distance_core_test.sv
